### hw/rtl/cfpc_pkg.sv
// ----------------------------------------------------------------------------
// cfpc_pkg
// shared types and constants of the framed columnar parser with crc-32 check
// ----------------------------------------------------------------------------
package cfpc_pkg;

   localparam int unsigned CounterWidthDefault = 32;
   localparam int unsigned RspFifoDepthDefault = 4;

   localparam logic [31:0] CrcPoly    = 32'hEDB88320;
   localparam logic [31:0] CrcOnes    = 32'hFFFFFFFF;
   localparam logic [31:0] FrameMagic = 32'h31584250;
   localparam logic [7:0]  FrameVer   = 8'd1;

   localparam logic [2:0] BC_DESC   = 3'd0;
   localparam logic [2:0] BC_FIXED  = 3'd1;
   localparam logic [2:0] BC_SLEN   = 3'd2;
   localparam logic [2:0] BC_SBODY  = 3'd3;
   localparam logic [2:0] BC_BITMAP = 3'd4;

   localparam logic [1:0] ST_DATA_OK = 2'd0;
   localparam logic [1:0] ST_MARK_OK = 2'd1;
   localparam logic [1:0] ST_FAILED  = 2'd2;

   localparam logic RK_BODY    = 1'b0;
   localparam logic RK_SUMMARY = 1'b1;

   localparam logic REG_STRING_TYPE = 1'b0;
   localparam logic REG_ERROR_MASK  = 1'b1;

   typedef struct packed {
      logic               record_kind;
      logic [2:0]         byte_class;
      logic [30:0]        column_index;
      logic [30:0]        element_index;
      logic [7:0]         body_byte;
      logic [1:0]         frame_status;
      logic [31:0]        frame_flags;
      logic [31:0]        sequence_res;
      logic signed [31:0] row_count;
      logic signed [31:0] column_count;
   } rsp_rec_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hw/rtl/cfpc_rsp_fifo.sv
// ----------------------------------------------------------------------------
// cfpc_rsp_fifo
// result queue: takes up to two beats per cycle; while out_stall is low, hands out one per cycle
// ----------------------------------------------------------------------------
module cfpc_rsp_fifo #(
   parameter int unsigned DEPTH = cfpc_pkg::RspFifoDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push0,
   input  logic                  push1,
   input  cfpc_pkg::rsp_rec_type rec0,
   input  cfpc_pkg::rsp_rec_type rec1,
   output logic                  nearly_full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output cfpc_pkg::rsp_rec_type out_rec,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import cfpc_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH+1);

   rsp_rec_type       mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [CW-1:0]     cnt_ff;
   logic              pop;
   logic [AW-1:0]     wr_nx;
   logic [1:0]        npush;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH-1)) ? '0 : p + AW'(1);
   endfunction

   assign pop         = out_valid && !out_stall;
   assign out_valid   = (cnt_ff != '0);
   assign out_rec     = mem_ff[rd_ff];
   assign nearly_full = (cnt_ff > CW'(DEPTH-2));
   assign count       = cnt_ff;
   assign wr_nx       = ptr_inc(wr_ff);
   assign npush       = {1'b0, push0} + {1'b0, push1};

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ff] <= rec0;
      end
      if (push1) begin
         mem_ff[push0 ? wr_nx : wr_ff] <= rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (npush == 2'd2) begin
            wr_ff <= ptr_inc(wr_nx);
         end else if (npush == 2'd1) begin
            wr_ff <= wr_nx;
         end
         if (pop) begin
            rd_ff <= ptr_inc(rd_ff);
         end
         cnt_ff <= cnt_ff + CW'(npush) - CW'(pop);
      end
   end

endmodule

### hw/rtl/columnar_frame_parser_crc_unit.sv
// ----------------------------------------------------------------------------
// columnar_frame_parser_crc_unit
// framed columnar record parser with reflected crc-32 trailer check
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  req     | in        | one frame byte with last mark
//  rsp     | out       | tagged body byte or frame summary
//  csr     | in/out    | apb register access
//
//  one byte accepted per cycle while req_stall is low; crc, parser and counters update in the accept cycle
//  results go through a small queue; req_stall rises while it cannot take two beats
//  the last byte of a frame adds the summary beat to the queue in its accept cycle
//  synchronous reset clears the frame state and sets default values in the registers
// ----------------------------------------------------------------------------
module columnar_frame_parser_crc_unit #(
   parameter int unsigned COUNTER_WIDTH = cfpc_pkg::CounterWidthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_frame_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_record_kind,
   output logic [2:0]         rsp_byte_class,
   output logic [30:0]        rsp_column_index,
   output logic [30:0]        rsp_element_index,
   output logic [7:0]         rsp_body_byte,
   output logic [1:0]         rsp_frame_status,
   output logic [31:0]        rsp_frame_flags,
   output logic [31:0]        rsp_sequence_res,
   output logic signed [31:0] rsp_row_count,
   output logic signed [31:0] rsp_column_count,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import cfpc_pkg::*;

   localparam int unsigned W = COUNTER_WIDTH;
   localparam logic [32:0] CntMax = (33'd1 << COUNTER_WIDTH) - 33'd1;
   localparam int unsigned FD = RspFifoDepthDefault;

   typedef enum logic [3:0] {
      PH_HDR, PH_MLEN, PH_MSG, PH_TYPE, PH_ESZ, PH_NSTR, PH_SLEN,
      PH_SBODY, PH_FIXED, PH_NWORDS, PH_BITMAP, PH_DONE_DATA, PH_DONE_MARK
   } phase_type;

   logic [31:0] stc_ff, mask_ff;

   logic [31:0]  crc_ff, crc_in;
   logic [7:0]   tr_ff [4];
   logic [7:0]   tr_in [4];
   logic [2:0]   tc_ff, tc_in;
   logic [W-1:0] bp_ff, bp_in;
   phase_type    ph_ff, ph_in;
   logic [31:0]  fs_ff, fs_in;
   logic [31:0]  hf_ff [4];
   logic [31:0]  hf_in [4];
   logic [W-1:0] cc_ff, cc_in, rc_ff, rc_in, bl_ff, bl_in, es_ff, es_in;
   logic         fail_ff, fail_in;

   logic         accept, body_emit, nsr, ncol, ah, dec_zero;
   logic [2:0]   cls;
   logic [W-1:0] elem, bl_dec;
   logic [7:0]   b;
   logic [31:0]  sh, col32, elem32, stored;
   logic [63:0]  prod;
   logic [32:0]  size;
   logic [1:0]   status;
   rsp_rec_type  body_rec, sum_rec;
   logic         nearly_full;
   rsp_rec_type  out_rec;
   logic [$clog2(FD+1)-1:0] fifo_cnt;

   assign accept    = req_valid && !req_stall;
   assign req_stall = nearly_full;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_ERROR_MASK) ? mask_ff : stc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stc_ff  <= '0;
         mask_ff <= 32'd2;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_STRING_TYPE: stc_ff  <= pwdata;
            REG_ERROR_MASK:  mask_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      crc_in = crc_ff; tc_in = tc_ff; bp_in = bp_ff; ph_in = ph_ff; fs_in = fs_ff;
      cc_in = cc_ff; rc_in = rc_ff; bl_in = bl_ff; es_in = es_ff; fail_in = fail_ff;
      for (int i = 0; i < 4; i++) begin
         tr_in[i] = tr_ff[i];
         hf_in[i] = hf_ff[i];
      end
      body_emit = 1'b0; cls = BC_DESC; elem = '0;
      nsr = 1'b0; ncol = 1'b0; ah = 1'b0;
      b      = tr_ff[0];
      sh     = {tr_ff[0], fs_ff[31:8]};
      bl_dec = bl_ff - W'(1);
      dec_zero = (bl_dec == '0);
      prod   = 64'(sh) * 64'(hf_ff[2]);
      size   = '0; stored = '0; status = ST_FAILED;
      sum_rec = '0;
      sum_rec.record_kind = RK_SUMMARY;
      if (accept) begin
         if (tc_ff == 3'd4) begin
            tr_in[0] = tr_ff[1]; tr_in[1] = tr_ff[2]; tr_in[2] = tr_ff[3];
            tr_in[3] = req_data_byte;
            crc_in = crc_byte(crc_ff, b);
            if ({1'b0, 32'(bp_ff)} != CntMax) begin
               bp_in = bp_ff + W'(1);
            end
            if (!fail_ff) begin
               unique case (ph_ff)
                  PH_HDR: begin
                     fs_in = sh;
                     if (bp_ff == W'(3) && sh != FrameMagic) fail_in = 1'b1;
                     else if (bp_ff == W'(4) && b != FrameVer) fail_in = 1'b1;
                     else if (bp_ff == W'(8)) hf_in[0] = sh;
                     else if (bp_ff == W'(12)) hf_in[1] = sh;
                     else if (bp_ff == W'(16)) hf_in[2] = sh;
                     else if (bp_ff == W'(20)) begin
                        hf_in[3] = sh;
                        if ((hf_ff[0] & mask_ff) != '0) begin
                           ph_in = PH_MLEN; bl_in = W'(4);
                        end else begin
                           ah = 1'b1;
                        end
                     end
                  end
                  PH_MSG: begin
                     bl_in = bl_dec;
                     if (dec_zero) ah = 1'b1;
                  end
                  PH_MLEN, PH_TYPE, PH_ESZ, PH_NSTR, PH_SLEN, PH_NWORDS: begin
                     if (ph_ff != PH_MLEN) begin
                        body_emit = 1'b1;
                        if (ph_ff == PH_SLEN) begin
                           cls = BC_SLEN; elem = rc_ff;
                        end
                     end
                     fs_in = sh;
                     bl_in = bl_dec;
                     if (dec_zero) begin
                        unique case (ph_ff)
                           PH_MLEN: begin
                              if ({1'b0, sh} > CntMax) fail_in = 1'b1;
                              else if (sh == '0) ah = 1'b1;
                              else begin ph_in = PH_MSG; bl_in = W'(sh); end
                           end
                           PH_TYPE: begin
                              es_in = (sh == stc_ff) ? W'(1) : W'(0);
                              ph_in = PH_ESZ; bl_in = W'(4);
                           end
                           PH_ESZ: begin
                              if (es_ff == W'(1)) begin
                                 ph_in = PH_NSTR; bl_in = W'(4);
                              end else if (sh[31]) fail_in = 1'b1;
                              else if (prod > 64'(CntMax)) fail_in = 1'b1;
                              else if (sh == '0) ncol = 1'b1;
                              else begin
                                 es_in = W'(sh); bl_in = W'(sh); rc_in = '0;
                                 ph_in = PH_FIXED;
                              end
                           end
                           PH_NSTR: begin
                              if (sh != hf_ff[2]) fail_in = 1'b1;
                              else begin rc_in = '0; ph_in = PH_SLEN; bl_in = W'(4); end
                           end
                           PH_SLEN: begin
                              if ({1'b0, sh} > CntMax) fail_in = 1'b1;
                              else if (sh == '0) nsr = 1'b1;
                              else begin ph_in = PH_SBODY; bl_in = W'(sh); end
                           end
                           default: begin
                              if ({sh, 3'b000} > 35'(CntMax)) fail_in = 1'b1;
                              else if (sh == '0) ph_in = PH_DONE_DATA;
                              else begin
                                 bl_in = W'({sh, 3'b000}); rc_in = '0; ph_in = PH_BITMAP;
                              end
                           end
                        endcase
                     end
                  end
                  PH_SBODY: begin
                     body_emit = 1'b1; cls = BC_SBODY; elem = rc_ff;
                     bl_in = bl_dec;
                     if (dec_zero) nsr = 1'b1;
                  end
                  PH_FIXED: begin
                     body_emit = 1'b1; cls = BC_FIXED; elem = rc_ff;
                     bl_in = bl_dec;
                     if (dec_zero) begin
                        rc_in = rc_ff + W'(1);
                        if (33'(rc_ff) + 33'd1 >= {1'b0, hf_ff[2]}) ncol = 1'b1;
                        else bl_in = es_ff;
                     end
                  end
                  PH_BITMAP: begin
                     body_emit = 1'b1; cls = BC_BITMAP; elem = rc_ff;
                     rc_in = rc_ff + W'(1);
                     bl_in = bl_dec;
                     if (dec_zero) ph_in = PH_DONE_DATA;
                  end
                  default: ;
               endcase
               if (nsr) begin
                  rc_in = rc_ff + W'(1);
                  if (33'(rc_ff) + 33'd1 >= {1'b0, hf_ff[2]}) ncol = 1'b1;
                  else begin ph_in = PH_SLEN; bl_in = W'(4); end
               end
               if (ncol) begin
                  cc_in = cc_ff + W'(1);
                  bl_in = W'(4);
                  if (33'(cc_ff) + 33'd1 >= {1'b0, hf_ff[3]}) begin
                     cc_in = '0; ph_in = PH_NWORDS;
                  end else begin
                     ph_in = PH_TYPE;
                  end
               end
               if (ah) begin
                  if ($signed(hf_in[2]) <= 0 || $signed(hf_in[3]) <= 0) ph_in = PH_DONE_MARK;
                  else if ({1'b0, hf_in[2]} > CntMax || {1'b0, hf_in[3]} > CntMax) begin
                     fail_in = 1'b1;
                  end else begin
                     cc_in = '0; ph_in = PH_TYPE; bl_in = W'(4);
                  end
               end
            end
         end else begin
            tr_in[tc_ff[1:0]] = req_data_byte;
            tc_in = tc_ff + 3'd1;
         end
         if (req_frame_last) begin
            size   = 33'(bp_in) + 33'(tc_in);
            stored = {tr_in[3], tr_in[2], tr_in[1], tr_in[0]};
            if (fail_in || size < 33'd8 || tc_in != 3'd4 || (crc_in ^ CrcOnes) != stored)
               status = ST_FAILED;
            else if (ph_in == PH_DONE_DATA) status = ST_DATA_OK;
            else if (ph_in == PH_DONE_MARK) status = ST_MARK_OK;
            else status = ST_FAILED;
            sum_rec.frame_status = status;
            sum_rec.frame_flags  = (status == ST_FAILED) ? '0 : hf_in[0];
            sum_rec.sequence_res = hf_in[1];
            sum_rec.row_count    = hf_in[2];
            sum_rec.column_count = hf_in[3];
            crc_in = CrcOnes; tc_in = '0; bp_in = '0; ph_in = PH_HDR; fs_in = '0;
            cc_in = '0; rc_in = '0; bl_in = '0; es_in = '0; fail_in = 1'b0;
            for (int i = 0; i < 4; i++) begin
               tr_in[i] = '0;
               hf_in[i] = '0;
            end
         end
      end
      col32  = 32'(cc_ff);
      elem32 = 32'(elem);
      body_rec = '0;
      body_rec.record_kind   = RK_BODY;
      body_rec.byte_class    = cls;
      body_rec.column_index  = col32[30:0];
      body_rec.element_index = elem32[30:0];
      body_rec.body_byte     = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CrcOnes; tc_ff <= '0; bp_ff <= '0; ph_ff <= PH_HDR; fs_ff <= '0;
         cc_ff <= '0; rc_ff <= '0; bl_ff <= '0; es_ff <= '0; fail_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            tr_ff[i] <= '0;
            hf_ff[i] <= '0;
         end
      end else begin
         crc_ff <= crc_in; tc_ff <= tc_in; bp_ff <= bp_in; ph_ff <= ph_in; fs_ff <= fs_in;
         cc_ff <= cc_in; rc_ff <= rc_in; bl_ff <= bl_in; es_ff <= es_in; fail_ff <= fail_in;
         for (int i = 0; i < 4; i++) begin
            tr_ff[i] <= tr_in[i];
            hf_ff[i] <= hf_in[i];
         end
      end
   end

   cfpc_rsp_fifo #(
      .DEPTH(FD)
   ) u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push0       (body_emit || (accept && req_frame_last)),
      .push1       (body_emit && accept && req_frame_last),
      .rec0        (body_emit ? body_rec : sum_rec),
      .rec1        (sum_rec),
      .nearly_full (nearly_full),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_rec     (out_rec),
      .count       (fifo_cnt)
   );

   assign rsp_record_kind   = out_rec.record_kind;
   assign rsp_byte_class    = out_rec.byte_class;
   assign rsp_column_index  = out_rec.column_index;
   assign rsp_element_index = out_rec.element_index;
   assign rsp_body_byte     = out_rec.body_byte;
   assign rsp_frame_status  = out_rec.frame_status;
   assign rsp_frame_flags   = out_rec.frame_flags;
   assign rsp_sequence_res  = out_rec.sequence_res;
   assign rsp_row_count     = out_rec.row_count;
   assign rsp_column_count  = out_rec.column_count;

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt <= ($clog2(FD+1))'(FD))
      else $error("result queue over depth");

   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> fifo_cnt <= ($clog2(FD+1))'(FD-2))
      else $error("beat accepted without room for two results");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_last |=> tc_ff == 3'd0 && ph_ff == PH_HDR && !fail_ff)
      else $error("frame state not cleared after last beat");

   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      fail_ff && !(accept && req_frame_last) |=> fail_ff)
      else $error("failure dropped inside a frame");

endmodule
